FILE: src/kfl_pkg.sv
// Shared types and constants of the keyframe lerp sampler.
package kfl_pkg;

   localparam int VALUE_W     = 32;
   localparam int DIFF_W      = VALUE_W + 1;
   localparam int KEY_COUNT_W = 7;
   localparam int KEY_INDEX_W = 6;
   localparam int NUM_COMP    = 3;
   localparam int COMP_W      = 2;

   typedef enum logic {
      CMD_WRITE  = 1'b0,
      CMD_SAMPLE = 1'b1
   } command_type;

   // One table entry: key time and the three vector components, Q16.16.
   typedef struct packed {
      logic [VALUE_W-1:0] key_time;
      logic [VALUE_W-1:0] value_x;
      logic [VALUE_W-1:0] value_y;
      logic [VALUE_W-1:0] value_z;
   } key_entry_type;

   // Start request for the fraction divider.
   typedef struct packed {
      logic               start;
      logic [VALUE_W-1:0] num;
      logic [VALUE_W-1:0] den;
   } div_req_type;

endpackage

FILE: src/keyframe_vec3_lerp_sampler.sv
// Top level of the keyframe vec3 linear interpolation sampler.
//
// The req channel carries one command per item. A write item stores a key
// time and an x/y/z vector at req_key_index and gives no result; writes to
// an index at or above MAX_KEYS are dropped. A sample item scans the first
// key_count entries, at most MAX_KEYS, and returns one rsp item: the vector
// clamped to the earliest or latest key, or linearly interpolated between
// the bracketing keys. With an empty table the rsp item carries zeros and
// rsp_no_keys. key_count must be set through the always ready csr channel
// only while idle; the block itself does not enforce this. A sample item
// passes over the table at one entry per cycle, once for the extremes and,
// if the query lies strictly inside them, once for the bracketing keys; if
// these have distinct times, the divider yields one fraction bit per cycle
// and three multiply-add steps follow. req_stall stays high until the
// result sits in the rsp register. A result held by rsp_stall keeps its
// payload; a following sample waits at its last step until the register is
// free. Synchronous reset returns the sequencer to idle, clears key_count
// and drops any pending result; the table is not cleared.
module keyframe_vec3_lerp_sampler #(
   parameter int MAX_KEYS      = 64,
   parameter int FRACTION_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_command,
   input  logic [kfl_pkg::KEY_INDEX_W-1:0]     req_key_index,
   input  logic signed [kfl_pkg::VALUE_W-1:0]  req_key_time_in,
   input  logic signed [kfl_pkg::VALUE_W-1:0]  req_value_x,
   input  logic signed [kfl_pkg::VALUE_W-1:0]  req_value_y,
   input  logic signed [kfl_pkg::VALUE_W-1:0]  req_value_z,
   input  logic signed [kfl_pkg::VALUE_W-1:0]  req_sample_time,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [kfl_pkg::VALUE_W-1:0]  rsp_out_x,
   output logic signed [kfl_pkg::VALUE_W-1:0]  rsp_out_y,
   output logic signed [kfl_pkg::VALUE_W-1:0]  rsp_out_z,
   output logic                                rsp_no_keys,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [kfl_pkg::KEY_COUNT_W-1:0]     csr_key_count
);
   import kfl_pkg::*;

   localparam int ADDR_W = $clog2(MAX_KEYS);
   localparam int CNT_W  = $clog2(MAX_KEYS + 1);
   localparam int PROD_W = DIFF_W + FRACTION_BITS + 1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN_EXT,
      ST_SCAN_BRK,
      ST_RD_LO,
      ST_RD_HI,
      ST_CAP_HI,
      ST_DIVIDE,
      ST_MUL,
      ST_ADD,
      ST_RESULT
   } state_type;

   state_type                 state_ff, state_in;
   logic [KEY_COUNT_W-1:0]    key_count_ff, key_count_in;
   logic [CNT_W-1:0]          n_ff, n_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic                      pend_ff, pend_in;
   logic [ADDR_W-1:0]         pend_idx_ff, pend_idx_in;
   logic signed [VALUE_W-1:0] t_ff, t_in;
   logic [ADDR_W-1:0]         lo_ff, lo_in, hi_ff, hi_in;
   logic signed [VALUE_W-1:0] lo_t_ff, lo_t_in, hi_t_ff, hi_t_in;
   logic                      direct_ff, direct_in;
   logic [COMP_W-1:0]         comp_ff, comp_in;
   logic signed [VALUE_W-1:0] vec_ff [NUM_COMP];
   logic signed [VALUE_W-1:0] vec_in [NUM_COMP];
   logic signed [DIFF_W-1:0]  diff_ff [NUM_COMP];
   logic signed [DIFF_W-1:0]  diff_in [NUM_COMP];
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic                      nokeys_ff, nokeys_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [VALUE_W-1:0] rsp_x_ff, rsp_y_ff, rsp_z_ff;
   logic                      rsp_nokeys_ff;

   logic                      req_acc;
   logic                      rsp_load;
   logic                      scanning, issue, scan_done;
   logic [31:0]               count_wide, index_wide;
   logic [CNT_W-1:0]          n_sel;
   logic                      wr_en;
   key_entry_type             wr_data, rd_data;
   logic [ADDR_W-1:0]         rd_addr;
   logic signed [VALUE_W-1:0] rd_time;
   logic signed [PROD_W-1:0]  prod_shift;
   div_req_type               div_req;
   logic                      div_busy;
   logic [FRACTION_BITS-1:0]  frac;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   // Writes land in the table at the accepting edge.
   assign index_wide = 32'(req_key_index);
   assign wr_en      = req_acc && (req_command == CMD_WRITE) && (index_wide < 32'(MAX_KEYS));
   assign wr_data    = '{key_time: req_key_time_in, value_x: req_value_x,
                         value_y: req_value_y, value_z: req_value_z};

   // Entries in use, limited to the table capacity.
   assign count_wide = 32'(key_count_ff);
   assign n_sel      = (count_wide > 32'(MAX_KEYS)) ? CNT_W'(MAX_KEYS) : CNT_W'(key_count_ff);

   // Both passes issue one read per cycle and evaluate the entry read in the
   // previous cycle, tagged by pend_idx_ff.
   assign scanning  = (state_ff == ST_SCAN_EXT) || (state_ff == ST_SCAN_BRK);
   assign issue     = scanning && (cnt_ff != n_ff);
   assign scan_done = scanning && (cnt_ff == n_ff) && !pend_ff;
   assign rd_time   = $signed(rd_data.key_time);

   always_comb begin
      unique case (state_ff)
         ST_RD_LO: rd_addr = lo_ff;
         ST_RD_HI: rd_addr = hi_ff;
         default:  rd_addr = cnt_ff[ADDR_W-1:0];
      endcase
   end

   kfl_key_ram #(
      .DEPTH  (MAX_KEYS),
      .ADDR_W (ADDR_W)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (index_wide[ADDR_W-1:0]),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // The divider starts when the bracketing pass ends with two distinct key
   // times; the lower time is strictly below the query and the upper strictly
   // above, so numerator and denominator are positive and num < den.
   always_comb begin
      div_req.start = (state_ff == ST_SCAN_BRK) && scan_done &&
                      !((lo_ff == hi_ff) || (lo_t_ff == hi_t_ff));
      div_req.num   = VALUE_W'(DIFF_W'(t_ff) - DIFF_W'(lo_t_ff));
      div_req.den   = VALUE_W'(DIFF_W'(hi_t_ff) - DIFF_W'(lo_t_ff));
   end

   kfl_frac_div #(
      .FRAC_W (FRACTION_BITS)
   ) u_frac_div (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .busy     (div_busy),
      .quotient (frac)
   );

   // An arithmetic shift of the product floors toward minus infinity.
   assign prod_shift = prod_ff >>> FRACTION_BITS;
   assign rsp_load   = (state_ff == ST_RESULT) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in     = state_ff;
      key_count_in = csr_valid ? csr_key_count : key_count_ff;
      n_in         = n_ff;
      cnt_in       = issue ? (cnt_ff + 1'b1) : cnt_ff;
      pend_in      = issue;
      pend_idx_in  = cnt_ff[ADDR_W-1:0];
      t_in         = t_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      lo_t_in      = lo_t_ff;
      hi_t_in      = hi_t_ff;
      direct_in    = direct_ff;
      comp_in      = comp_ff;
      vec_in       = vec_ff;
      diff_in      = diff_ff;
      prod_in      = prod_ff;
      nokeys_in    = nokeys_ff;

      // Extremes pass: the first minimum and first maximum in index order.
      if (pend_ff && (state_ff == ST_SCAN_EXT)) begin
         if (pend_idx_ff == '0) begin
            lo_in   = pend_idx_ff;
            hi_in   = pend_idx_ff;
            lo_t_in = rd_time;
            hi_t_in = rd_time;
         end else begin
            if (rd_time < lo_t_ff) begin
               lo_in   = pend_idx_ff;
               lo_t_in = rd_time;
            end
            if (rd_time > hi_t_ff) begin
               hi_in   = pend_idx_ff;
               hi_t_in = rd_time;
            end
         end
      end

      // Bracketing pass: the last key in index order wins among equal times.
      if (pend_ff && (state_ff == ST_SCAN_BRK)) begin
         if ((rd_time <= t_ff) && (rd_time >= lo_t_ff)) begin
            lo_in   = pend_idx_ff;
            lo_t_in = rd_time;
         end
         if ((rd_time >= t_ff) && (rd_time <= hi_t_ff)) begin
            hi_in   = pend_idx_ff;
            hi_t_in = rd_time;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc && (req_command == CMD_SAMPLE)) begin
               n_in   = n_sel;
               t_in   = req_sample_time;
               cnt_in = '0;
               if (n_sel == '0) begin
                  for (int k = 0; k < NUM_COMP; k++) begin
                     vec_in[k] = '0;
                  end
                  nokeys_in = 1'b1;
                  state_in  = ST_RESULT;
               end else begin
                  nokeys_in = 1'b0;
                  state_in  = ST_SCAN_EXT;
               end
            end
         end
         ST_SCAN_EXT: begin
            if (scan_done) begin
               cnt_in = '0;
               if (t_ff <= lo_t_ff) begin
                  direct_in = 1'b1;
                  state_in  = ST_RD_LO;
               end else if (t_ff >= hi_t_ff) begin
                  lo_in     = hi_ff;
                  direct_in = 1'b1;
                  state_in  = ST_RD_LO;
               end else begin
                  state_in = ST_SCAN_BRK;
               end
            end
         end
         ST_SCAN_BRK: begin
            if (scan_done) begin
               direct_in = !div_req.start;
               state_in  = ST_RD_LO;
            end
         end
         ST_RD_LO: begin
            state_in = ST_RD_HI;
         end
         ST_RD_HI: begin
            // Read data now holds the lower key.
            vec_in[0] = $signed(rd_data.value_x);
            vec_in[1] = $signed(rd_data.value_y);
            vec_in[2] = $signed(rd_data.value_z);
            state_in  = direct_ff ? ST_RESULT : ST_CAP_HI;
         end
         ST_CAP_HI: begin
            diff_in[0] = DIFF_W'($signed(rd_data.value_x)) - DIFF_W'(vec_ff[0]);
            diff_in[1] = DIFF_W'($signed(rd_data.value_y)) - DIFF_W'(vec_ff[1]);
            diff_in[2] = DIFF_W'($signed(rd_data.value_z)) - DIFF_W'(vec_ff[2]);
            state_in   = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (!div_busy) begin
               comp_in  = '0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = PROD_W'(diff_ff[comp_ff]) * PROD_W'($signed({1'b0, frac}));
            state_in = ST_ADD;
         end
         ST_ADD: begin
            vec_in[comp_ff] = vec_ff[comp_ff] + $signed(prod_shift[VALUE_W-1:0]);
            if (comp_ff == COMP_W'(NUM_COMP - 1)) begin
               state_in = ST_RESULT;
            end else begin
               comp_in  = comp_ff + 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_RESULT: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         key_count_ff <= '0;
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         key_count_ff <= key_count_in;
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff        <= n_in;
      pend_idx_ff <= pend_idx_in;
      t_ff        <= t_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      lo_t_ff     <= lo_t_in;
      hi_t_ff     <= hi_t_in;
      direct_ff   <= direct_in;
      comp_ff     <= comp_in;
      vec_ff      <= vec_in;
      diff_ff     <= diff_in;
      prod_ff     <= prod_in;
      nokeys_ff   <= nokeys_in;
      if (rsp_load) begin
         rsp_x_ff      <= vec_ff[0];
         rsp_y_ff      <= vec_ff[1];
         rsp_z_ff      <= vec_ff[2];
         rsp_nokeys_ff <= nokeys_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_out_x   = rsp_x_ff;
   assign rsp_out_y   = rsp_y_ff;
   assign rsp_out_z   = rsp_z_ff;
   assign rsp_no_keys = rsp_nokeys_ff;

`ifndef SYNTHESIS
   // The fraction must be complete before the first multiplication.
   a_mul_after_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL) |-> !div_busy)
      else $error("multiplication started while the divider is busy");

   // Every evaluated entry lies inside the range of keys in use.
   a_pend_in_range: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (CNT_W'(pend_idx_ff) < n_ff))
      else $error("scanned entry beyond the keys in use");

   // During the bracketing pass the query stays between the bracket times.
   a_bracket_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN_BRK) |-> ((lo_t_ff <= t_ff) && (hi_t_ff >= t_ff)))
      else $error("bracket times do not enclose the query time");

   // An empty-table result carries a zero vector.
   a_no_keys_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_nokeys_ff) |->
         ((rsp_x_ff == '0) && (rsp_y_ff == '0) && (rsp_z_ff == '0)))
      else $error("empty-table result with a nonzero vector");
`endif

endmodule

FILE: src/kfl_key_ram.sv
// Keyframe table memory: one write port, one read port with registered data.
module kfl_key_ram #(
   parameter int DEPTH  = 64,
   parameter int ADDR_W = 6
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_W-1:0]     wr_addr,
   input  kfl_pkg::key_entry_type wr_data,
   input  logic [ADDR_W-1:0]     rd_addr,
   output kfl_pkg::key_entry_type rd_data
);
   import kfl_pkg::*;

   key_entry_type mem [DEPTH];
   key_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/kfl_frac_div.sv
// Serial restoring divider for the interpolation fraction, one quotient bit per cycle.
module kfl_frac_div #(
   parameter int FRAC_W = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  kfl_pkg::div_req_type div_req,
   output logic                 busy,
   output logic [FRAC_W-1:0]    quotient
);
   import kfl_pkg::*;

   localparam int STEP_W = $clog2(FRAC_W + 1);

   logic               busy_ff, busy_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [VALUE_W-1:0] rem_ff, rem_in;
   logic [VALUE_W-1:0] den_ff, den_in;
   logic [FRAC_W-1:0]  quo_ff, quo_in;
   logic [VALUE_W:0]   shifted;
   logic [VALUE_W:0]   trial;
   logic               fits;

   // The caller guarantees num < den, so the remainder stays below den and
   // the quotient needs exactly FRAC_W bits.
   always_comb begin
      shifted = {rem_ff, 1'b0};
      trial   = shifted - {1'b0, den_ff};
      fits    = (shifted >= {1'b0, den_ff});
      busy_in = busy_ff;
      step_in = step_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(FRAC_W);
         rem_in  = div_req.num;
         den_in  = div_req.den;
         quo_in  = '0;
      end else if (busy_ff) begin
         rem_in  = fits ? trial[VALUE_W-1:0] : shifted[VALUE_W-1:0];
         quo_in  = {quo_ff[FRAC_W-2:0], fits};
         step_in = step_ff - 1'b1;
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule
